// ----- rtl/svil_pkg.sv -----
// Shared types and constants for the sorted value index lookup block.
// Used by svil_cell, svil_or_tree and sorted_value_index_lookup; no dependencies.
`default_nettype none

package svil_pkg;

	localparam int DEF_ENTRIES = 256;
	localparam int VALUE_W     = 32;
	localparam int INDEX_W     = 8;
	localparam int COUNT_W     = 9;
	localparam int KIND_W      = 2;
	localparam int TREE_FANIN  = 16;
	localparam int TREE_LG     = 4;

	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

	// Broadcast from the controller to every cell of the chain.
	typedef struct packed {
		logic                      ins_en;
		logic signed [VALUE_W-1:0] value;
	} cell_cmd_t;

	// Per-cell match report; at most one cell sets hit, so an OR tree merges them.
	typedef struct packed {
		logic               hit;
		logic [INDEX_W-1:0] idx;
		logic               dup;
	} match_t;

	localparam int MATCH_W = $bits(match_t);

	// Registered levels of the fanin-16 OR tree for n leaves.
	function automatic int tree_levels(input int n);
		int lg;
		lg = $clog2(n);
		return (lg + TREE_LG - 1) / TREE_LG;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/svil_cell.sv -----
// One slot of the sorted table chain: holds a value and its arrival position.
// Uses svil_pkg; takes its left neighbor's data when an insert shifts the row.
`default_nettype none

module svil_cell #(
	parameter int IDX   = 0,
	parameter int POS_W = 8,
	parameter int CNT_W = 9
) (
	input  wire                                      clk,
	input  wire  svil_pkg::cell_cmd_t                cmd,
	input  wire  [CNT_W-1:0]                         count,
	input  wire  [POS_W-1:0]                         new_pos,
	input  wire                                      left_ins,
	input  wire                                      left_eq,
	input  wire  signed [svil_pkg::VALUE_W-1:0]      left_val,
	input  wire  [POS_W-1:0]                         left_pos,
	output logic                                     ins,
	output logic                                     eq,
	output logic signed [svil_pkg::VALUE_W-1:0]      val,
	output logic [POS_W-1:0]                         pos,
	output svil_pkg::match_t                         match
);

	logic signed [svil_pkg::VALUE_W-1:0] val_q;
	logic [POS_W-1:0]                    pos_q;
	svil_pkg::match_t                    match_q;
	logic                                occ;

	always_comb begin
		occ = CNT_W'(IDX) < count;
		eq  = occ && (val_q == cmd.value);
		// insertion point and everything above it: empty or strictly greater
		ins = !occ || (val_q > cmd.value);
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_en && ins) begin
			if (left_ins) begin
				val_q <= left_val;
				pos_q <= left_pos;
			end else begin
				val_q <= cmd.value;
				pos_q <= new_pos;
			end
		end
		// equal values sit together, so the first of a run is the only hit
		match_q.hit <= eq && !left_eq;
		match_q.idx <= (eq && !left_eq) ? svil_pkg::INDEX_W'(pos_q) : '0;
		match_q.dup <= eq;
	end

	assign val   = val_q;
	assign pos   = pos_q;
	assign match = match_q;

endmodule

`default_nettype wire

// ----- rtl/svil_or_tree.sv -----
// Registered OR reduction tree, fanin 16, one register level per tree level.
// Uses svil_pkg for the fanin and level count.
`default_nettype none

module svil_or_tree #(
	parameter int N = 256,
	parameter int W = 10
) (
	input  wire                clk,
	input  wire  [N-1:0][W-1:0] leaf,
	output logic [W-1:0]       root
);

	localparam int LEVELS = svil_pkg::tree_levels(N);
	localparam int PAD    = 1 << (svil_pkg::TREE_LG * LEVELS);

	logic [W-1:0] base [PAD];
	logic [W-1:0] lvl  [LEVELS][PAD];

	for (genvar j = 0; j < PAD; j++) begin : g_base
		if (j < N) begin : g_real
			assign base[j] = leaf[j];
		end else begin : g_pad
			assign base[j] = '0;
		end
	end

	for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
		localparam int NODES = PAD >> (svil_pkg::TREE_LG * (l + 1));
		for (genvar j = 0; j < PAD; j++) begin : g_node
			if (j < NODES) begin : g_used
				logic [W-1:0] acc;
				always_comb begin
					acc = '0;
					for (int k = 0; k < svil_pkg::TREE_FANIN; k++) begin
						if (l == 0) begin
							acc = acc | base[j * svil_pkg::TREE_FANIN + k];
						end else begin
							acc = acc | lvl[(l == 0) ? 0 : l - 1][j * svil_pkg::TREE_FANIN + k];
						end
					end
				end
				always_ff @(posedge clk) begin
					lvl[l][j] <= acc;
				end
			end else begin : g_idle
				assign lvl[l][j] = '0;
			end
		end
	end

	assign root = lvl[LEVELS-1][0];

endmodule

`default_nettype wire

// ----- rtl/sorted_value_index_lookup.sv -----
// Top level of the sorted value index lookup block: controller, cell chain, match tree.
// Uses svil_pkg, svil_cell and svil_or_tree.
`default_nettype none

// Keeps up to ENTRIES signed 32-bit values in ascending order in a chain of cells,
// each value paired with its arrival position since the last clear. tuser[1:0]
// carries the kind (clear, append, look up); tdata[31:0] the value. An append
// shifts the cells above the insertion point one place up together; a lookup
// compares in every cell at once and a registered fanin-16 OR tree merges the
// per-cell match. One request is handled at a time; its result is offered after
// the states EXEC, REDUCE and DONE, REDUCE waiting out the depth of the match
// tree. The next request can be taken in the cycle after the result is taken,
// not before.
module sorted_value_index_lookup #(
	parameter int ENTRIES = svil_pkg::DEF_ENTRIES
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,  // [31:0] value
	input  wire  [1:0]  s_tuser,  // [1:0] kind
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata   // [0] found, [8:1] initial_index, [9] all_unique,
	                              // [10] full_res, [19:11] count, [23:20] zero
);

	localparam int POS_W  = $clog2(ENTRIES);
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int LEVELS = svil_pkg::tree_levels(ENTRIES);
	localparam int LVL_W  = $clog2(LEVELS + 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EXEC   = 5'b00010,
		ST_REDUCE = 5'b00100,
		ST_DONE   = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

	state_t                                state_q;
	logic [svil_pkg::KIND_W-1:0]           kind_q;
	logic signed [svil_pkg::VALUE_W-1:0]   value_q;
	logic [CNT_W-1:0]                      count_q;
	logic                                  dup_q;
	logic                                  full_q;
	logic [LVL_W-1:0]                      lvl_cnt_q;
	logic [23:0]                           tdata_q;

	svil_pkg::cell_cmd_t                   cmd;
	logic                                  is_full;
	logic                                  is_append;
	logic                                  dup_next;
	svil_pkg::match_t                      root;

	logic                                  ins_w  [ENTRIES];
	logic                                  eq_w   [ENTRIES];
	logic signed [svil_pkg::VALUE_W-1:0]   val_w  [ENTRIES];
	logic [POS_W-1:0]                      pos_w  [ENTRIES];
	logic [ENTRIES-1:0][svil_pkg::MATCH_W-1:0] match_w;

	assign is_full   = count_q == CNT_W'(ENTRIES);
	assign is_append = kind_q == svil_pkg::KIND_APPEND;

	always_comb begin
		cmd.ins_en = (state_q == ST_EXEC) && is_append && !is_full;
		cmd.value  = value_q;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		svil_pkg::match_t m;
		if (i == 0) begin : g_first
			svil_cell #(.IDX(i), .POS_W(POS_W), .CNT_W(CNT_W)) u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.count    (count_q),
				.new_pos  (count_q[POS_W-1:0]),
				.left_ins (1'b0),
				.left_eq  (1'b0),
				.left_val ('0),
				.left_pos ('0),
				.ins      (ins_w[i]),
				.eq       (eq_w[i]),
				.val      (val_w[i]),
				.pos      (pos_w[i]),
				.match    (m)
			);
		end else begin : g_rest
			svil_cell #(.IDX(i), .POS_W(POS_W), .CNT_W(CNT_W)) u_cell (
				.clk      (clk),
				.cmd      (cmd),
				.count    (count_q),
				.new_pos  (count_q[POS_W-1:0]),
				.left_ins (ins_w[i-1]),
				.left_eq  (eq_w[i-1]),
				.left_val (val_w[i-1]),
				.left_pos (pos_w[i-1]),
				.ins      (ins_w[i]),
				.eq       (eq_w[i]),
				.val      (val_w[i]),
				.pos      (pos_w[i]),
				.match    (m)
			);
		end
		assign match_w[i] = m;
	end

	svil_or_tree #(.N(ENTRIES), .W(svil_pkg::MATCH_W)) u_tree (
		.clk  (clk),
		.leaf (match_w),
		.root (root)
	);

	// a duplicate counts only for an append that was stored
	assign dup_next = dup_q || (is_append && !full_q && root.dup);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			dup_q     <= 1'b0;
			lvl_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					lvl_cnt_q <= '0;
					state_q   <= ST_REDUCE;
					if (kind_q == svil_pkg::KIND_CLEAR) begin
						count_q <= '0;
						dup_q   <= 1'b0;
					end else if (is_append && !is_full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				ST_REDUCE: begin
					lvl_cnt_q <= lvl_cnt_q + LVL_W'(1);
					if (lvl_cnt_q == LVL_W'(LEVELS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					dup_q   <= dup_next;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			kind_q  <= s_tuser;
			value_q <= s_tdata;
		end
		if (state_q == ST_EXEC) begin
			full_q <= is_append && is_full;
		end
		if (state_q == ST_DONE) begin
			tdata_q[0]     <= (kind_q == svil_pkg::KIND_LOOKUP) && root.hit;
			tdata_q[8:1]   <= (kind_q == svil_pkg::KIND_LOOKUP) ? root.idx : '0;
			tdata_q[9]     <= !dup_next;
			tdata_q[10]    <= full_q;
			tdata_q[19:11] <= svil_pkg::COUNT_W'(count_q);
			tdata_q[23:20] <= '0;
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = state_q == ST_OUT;
	assign m_tdata  = tdata_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb_sorted_value_index_lookup.sv -----
// Testbench for sorted_value_index_lookup: directed rows, then random clear/append/lookup
// runs under changing back-pressure, each result checked against a table model kept here or a pinned row.
// Depends on svil_pkg and the sorted_value_index_lookup RTL.
`default_nettype none

module tb_sorted_value_index_lookup;

	localparam int TABLE_DEPTH = svil_pkg::DEF_ENTRIES;
	localparam logic [svil_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int LOOKUP_LATENCY = 2 + svil_pkg::tree_levels(TABLE_DEPTH);
	localparam int LONG_HOLD = 300;
	localparam int PHASE_ITEMS = 310;

	// Field order matches m_tdata[19:0], found in bit 0.
	typedef struct packed {
		logic [svil_pkg::COUNT_W-1:0] count;
		logic                         full_res;
		logic                         all_unique;
		logic [svil_pkg::INDEX_W-1:0] initial_index;
		logic                         found;
	} lookup_result_t;

	typedef struct {
		logic [svil_pkg::KIND_W-1:0] kind;
		logic [31:0]                 value;
		bit                          pinned;
		lookup_result_t              result;
	} table_row_t;

	typedef struct {
		bit             pinned;
		lookup_result_t result;
	} pinned_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	// Model of the table: values in ascending order, ties by arrival position
	logic signed [31:0] stored_vals[$];
	int                 stored_pos[$];
	bit                 dup_seen = 1'b0;

	lookup_result_t results_due[$];
	pinned_result_t pinned_due[$];
	table_row_t     directed_rows[$];

	int errors = 0;
	int items_sent = 0;
	int send_idle = 0;
	int recv_idle = 0;
	bit hold_armed = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	sorted_value_index_lookup dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #1 clk = ~clk;

	function automatic lookup_result_t step_table(logic [svil_pkg::KIND_W-1:0] kind,
			logic signed [31:0] v);
		lookup_result_t r;
		int slot;
		r = '0;
		slot = 0;
		case (kind)
			svil_pkg::KIND_CLEAR: begin
				stored_vals.delete();
				stored_pos.delete();
				dup_seen = 1'b0;
			end
			svil_pkg::KIND_APPEND: begin
				if (stored_vals.size() >= TABLE_DEPTH) begin
					r.full_res = 1'b1;
				end else begin
					// insert after any equal values
					while (slot < stored_vals.size() && stored_vals[slot] <= v)
						slot++;
					if (slot > 0 && stored_vals[slot-1] == v)
						dup_seen = 1'b1;
					stored_pos.insert(slot, stored_vals.size());
					stored_vals.insert(slot, v);
				end
			end
			svil_pkg::KIND_LOOKUP: begin
				while (slot < stored_vals.size() && stored_vals[slot] < v)
					slot++;
				if (slot < stored_vals.size() && stored_vals[slot] == v) begin
					r.found = 1'b1;
					r.initial_index = svil_pkg::INDEX_W'(stored_pos[slot]);
				end
			end
			default: ;
		endcase
		r.all_unique = !dup_seen;
		r.count = svil_pkg::COUNT_W'(stored_vals.size());
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Compare results first, then predict the request taken at the same edge.
	always @(posedge clk) begin : check_results
		lookup_result_t got;
		lookup_result_t want;
		pinned_result_t pin;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[19:0];
				if (results_due.size() == 0) begin
					$error("result with no request outstanding: m_tdata=%h", m_tdata);
					errors++;
				end else begin
					want = results_due.pop_front();
					check_field("found", want.found, got.found);
					check_field("initial_index", want.initial_index, got.initial_index);
					check_field("all_unique", want.all_unique, got.all_unique);
					check_field("full_res", want.full_res, got.full_res);
					check_field("count", want.count, got.count);
					check_field("tdata padding", 0, m_tdata[23:20]);
				end
			end
			if (s_tvalid && s_tready) begin
				want = step_table(s_tuser, s_tdata);
				if (pinned_due.size() != 0) begin
					pin = pinned_due.pop_front();
					if (pin.pinned)
						want = pin.result;
				end
				results_due.push_back(want);
			end
		end
	end

	// Receiver: random back-pressure plus one long hold on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_armed && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= LONG_HOLD;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send_item(logic [svil_pkg::KIND_W-1:0] kind, logic [31:0] value);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= value;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// Small signed pool for ties, stored values for hits, extremes, full-range noise
	function automatic logic [31:0] pick_value();
		int sel;
		sel = $urandom_range(99);
		if (sel < 40)
			return 32'(int'($urandom_range(15)) - 8);
		if (sel < 70 && stored_vals.size() > 0)
			return stored_vals[$urandom_range(stored_vals.size() - 1)];
		if (sel < 80) begin
			case ($urandom_range(3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'hFFFF_FFFF;
				default: return 32'h0;
			endcase
		end
		return $urandom();
	endfunction

	task automatic run_episode(int len);
		int sel;
		send_item(svil_pkg::KIND_CLEAR, $urandom());
		for (int i = 0; i < len; i++) begin
			sel = $urandom_range(99);
			if (sel < 55)
				send_item(svil_pkg::KIND_APPEND, pick_value());
			else if (sel < 93)
				send_item(svil_pkg::KIND_LOOKUP, pick_value());
			else if (sel < 96)
				send_item(KIND_UNUSED, $urandom());
			else
				send_item(svil_pkg::KIND_CLEAR, $urandom());
		end
	endtask

	// Fill the table to the top, then push past it
	task automatic run_fill();
		logic [31:0] last_val;
		send_item(svil_pkg::KIND_CLEAR, 32'h0);
		for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
			send_item(svil_pkg::KIND_APPEND, pick_value());
			if ($urandom_range(9) == 0)
				send_item(svil_pkg::KIND_LOOKUP, pick_value());
		end
		last_val = $urandom();
		send_item(svil_pkg::KIND_APPEND, last_val);
		send_item(svil_pkg::KIND_LOOKUP, last_val);
		repeat (6) begin
			send_item(svil_pkg::KIND_APPEND, pick_value());
			send_item(svil_pkg::KIND_LOOKUP, pick_value());
		end
	endtask

	task automatic table_row(logic [svil_pkg::KIND_W-1:0] kind, logic [31:0] value,
			bit pinned, int count, bit uniq);
		table_row_t row;
		row.kind = kind;
		row.value = value;
		row.pinned = pinned;
		row.result = '0;
		row.result.count = svil_pkg::COUNT_W'(count);
		row.result.all_unique = uniq;
		directed_rows.push_back(row);
	endtask

	initial begin : stimulus
		int phase_start;
		table_row_t row;
		pinned_result_t pin;

		send_idle = 36;
		recv_idle = 63;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// kind, value, pinned, count, all_unique (pinned rows expect found/index/full zero)
		table_row(svil_pkg::KIND_LOOKUP, 32'h0000_0000, 1, 0, 1);
		table_row(KIND_UNUSED, 32'hFFFF_FFFF, 1, 0, 1);
		table_row(svil_pkg::KIND_CLEAR, 32'hFFFF_FFFF, 1, 0, 1);
		table_row(svil_pkg::KIND_APPEND, 32'h7FFF_FFFF, 1, 1, 1);
		table_row(svil_pkg::KIND_APPEND, 32'h8000_0000, 1, 2, 1);
		table_row(svil_pkg::KIND_APPEND, 32'h0000_0000, 1, 3, 1);
		table_row(svil_pkg::KIND_LOOKUP, 32'h8000_0000, 0, 0, 0);
		table_row(svil_pkg::KIND_LOOKUP, 32'h7FFF_FFFF, 0, 0, 0);
		table_row(svil_pkg::KIND_LOOKUP, 32'h7FFF_FFFE, 0, 0, 0);
		table_row(svil_pkg::KIND_APPEND, 32'h0000_0000, 0, 0, 0);
		table_row(svil_pkg::KIND_LOOKUP, 32'h0000_0000, 0, 0, 0);
		table_row(svil_pkg::KIND_APPEND, 32'hFFFF_FFFF, 0, 0, 0);
		table_row(svil_pkg::KIND_APPEND, 32'h0000_0001, 0, 0, 0);
		table_row(svil_pkg::KIND_APPEND, 32'h5555_5555, 0, 0, 0);
		table_row(svil_pkg::KIND_APPEND, 32'hAAAA_AAAA, 0, 0, 0);
		table_row(svil_pkg::KIND_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0);
		table_row(svil_pkg::KIND_LOOKUP, 32'hAAAA_AAAA, 0, 0, 0);
		table_row(KIND_UNUSED, 32'h0000_0000, 0, 0, 0);
		table_row(svil_pkg::KIND_CLEAR, 32'h0000_0000, 1, 0, 1);
		table_row(svil_pkg::KIND_LOOKUP, 32'h0000_0000, 1, 0, 1);
		table_row(svil_pkg::KIND_APPEND, 32'h8000_0000, 1, 1, 1);
		table_row(svil_pkg::KIND_APPEND, 32'h8000_0000, 1, 2, 0);
		table_row(svil_pkg::KIND_LOOKUP, 32'h8000_0000, 0, 0, 0);
		table_row(svil_pkg::KIND_CLEAR, 32'h0000_0000, 1, 0, 1);

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			pin.pinned = row.pinned;
			pin.result = row.result;
			pinned_due.push_back(pin);
			send_item(row.kind, row.value);
		end

		// slow receiver, with one long hold early on
		phase_start = items_sent;
		run_episode(20);
		hold_armed = 1'b1;
		while (items_sent - phase_start < PHASE_ITEMS)
			run_episode($urandom_range(1, 60));

		// slow sender
		send_idle = 63;
		recv_idle = 36;
		phase_start = items_sent;
		while (items_sent - phase_start < PHASE_ITEMS)
			run_episode($urandom_range(1, 60));

		// full rate
		send_idle = 0;
		recv_idle = 0;
		phase_start = items_sent;
		run_fill();
		while (items_sent - phase_start < PHASE_ITEMS)
			run_episode($urandom_range(1, 60));

		s_tvalid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (4 * LOOKUP_LATENCY) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#400000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/svil_pkg.sv
rtl/svil_cell.sv
rtl/svil_or_tree.sv
rtl/sorted_value_index_lookup.sv
tb/sv/tb_sorted_value_index_lookup.sv
